// ===== rtl/rhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsl_pkg
// shared constants and types of the rgb to hsl converter
// ----------------------------------------------------------------------------
`default_nettype none

package rhsl_pkg;

	// default channel width, full scale is 2^bits - 1
	localparam int CHANNEL_BITS_DEF = 8;

	// fraction bits of hue and saturation, one quotient bit per divider stage
	localparam int QUO_BITS = 16;

	// which channel holds the maximum
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

endpackage

`default_nettype wire

// ===== rtl/rhsl_if.sv =====
// ----------------------------------------------------------------------------
// rhsl_if
// valid/ready channels of the converter: rgb pixel in, hsl word out
// ----------------------------------------------------------------------------
`default_nettype none

interface rhsl_in_if #(
	parameter int CHANNEL_BITS = rhsl_pkg::CHANNEL_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsl_out_if #(
	parameter int CHANNEL_BITS = rhsl_pkg::CHANNEL_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [rhsl_pkg::QUO_BITS-1:0] hue;
	logic [rhsl_pkg::QUO_BITS-1:0] saturation;
	logic [CHANNEL_BITS:0]         lightness_sum;
	logic                          achromatic;

	modport source (output valid, output hue, output saturation, output lightness_sum,
		output achromatic, input ready);
	modport sink   (input valid, input hue, input saturation, input lightness_sum,
		input achromatic, output ready);
endinterface

`default_nettype wire

// ===== rtl/rhsl_div_step.sv =====
// ----------------------------------------------------------------------------
// rhsl_div_step
// one restoring step of both dividers (saturation and hue) in its own stage
// ----------------------------------------------------------------------------
`default_nettype none

module rhsl_div_step #(
	parameter int CHANNEL_BITS = rhsl_pkg::CHANNEL_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          up_valid,
	output      logic                          up_ready,
	input  wire logic [CHANNEL_BITS-1:0]       up_sat_rem,
	input  wire logic [rhsl_pkg::QUO_BITS-1:0] up_sat_num,
	input  wire logic [CHANNEL_BITS-1:0]       up_sat_div,
	input  wire logic [rhsl_pkg::QUO_BITS-1:0] up_sat_quo,
	input  wire logic [CHANNEL_BITS+2:0]       up_hue_rem,
	input  wire logic [CHANNEL_BITS+2:0]       up_hue_div,
	input  wire logic [rhsl_pkg::QUO_BITS-1:0] up_hue_quo,
	input  wire logic [CHANNEL_BITS:0]         up_lsum,
	input  wire logic                          up_achrom,
	output      logic                          dn_valid,
	input  wire logic                          dn_ready,
	output      logic [CHANNEL_BITS-1:0]       dn_sat_rem,
	output      logic [rhsl_pkg::QUO_BITS-1:0] dn_sat_num,
	output      logic [CHANNEL_BITS-1:0]       dn_sat_div,
	output      logic [rhsl_pkg::QUO_BITS-1:0] dn_sat_quo,
	output      logic [CHANNEL_BITS+2:0]       dn_hue_rem,
	output      logic [CHANNEL_BITS+2:0]       dn_hue_div,
	output      logic [rhsl_pkg::QUO_BITS-1:0] dn_hue_quo,
	output      logic [CHANNEL_BITS:0]         dn_lsum,
	output      logic                          dn_achrom
);
	import rhsl_pkg::*;

	logic                    valid_q;
	logic                    load;
	logic [CHANNEL_BITS:0]   sat_trial;
	logic                    sat_ge;
	logic [CHANNEL_BITS:0]   sat_diff;
	logic [CHANNEL_BITS+3:0] hue_trial;
	logic                    hue_ge;
	logic [CHANNEL_BITS+3:0] hue_diff;

	assign up_ready = !valid_q || dn_ready;
	assign load     = up_valid && up_ready;
	assign dn_valid = valid_q;

	// saturation: bring down the next numerator bit
	always_comb begin
		sat_trial = {up_sat_rem, up_sat_num[QUO_BITS-1]};
		sat_ge    = sat_trial >= {1'b0, up_sat_div};
		sat_diff  = sat_trial - {1'b0, up_sat_div};
	end

	// hue: numerator is n * 2^16, so a zero comes down each step
	always_comb begin
		hue_trial = {up_hue_rem, 1'b0};
		hue_ge    = hue_trial >= {1'b0, up_hue_div};
		hue_diff  = hue_trial - {1'b0, up_hue_div};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dn_sat_rem <= sat_ge ? sat_diff[CHANNEL_BITS-1:0] : sat_trial[CHANNEL_BITS-1:0];
			dn_sat_num <= {up_sat_num[QUO_BITS-2:0], 1'b0};
			dn_sat_div <= up_sat_div;
			dn_sat_quo <= {up_sat_quo[QUO_BITS-2:0], sat_ge};
			dn_hue_rem <= hue_ge ? hue_diff[CHANNEL_BITS+2:0] : hue_trial[CHANNEL_BITS+2:0];
			dn_hue_div <= up_hue_div;
			dn_hue_quo <= {up_hue_quo[QUO_BITS-2:0], hue_ge};
			dn_lsum    <= up_lsum;
			dn_achrom  <= up_achrom;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsl_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// rgb pixel to hue, saturation and lightness sum, fully pipelined
// ----------------------------------------------------------------------------
//
//   channel    dir   payload                                        role
//   pix_in     in    red, green, blue                               pixel word
//   pix_out    out   hue, saturation, lightness_sum, achromatic     hsl word
//
// one word per clock sustained while pix_out is ready; 3 + 16 = 19 register
// stages, set by the two 16-step restoring dividers, which take one quotient
// bit per stage side by side. a word passes stages 1 to 3 and then the
// sixteen divider stages, the last of which is the result register.
// reset (arst_n, async, low) clears only the stage valid bits.
// every stage holds its word while the next one is full and stalled, so a
// stall fills bubbles first and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_converter #(
	parameter int CHANNEL_BITS = rhsl_pkg::CHANNEL_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rhsl_in_if.sink  pix_in,
	rhsl_out_if.source pix_out
);
	import rhsl_pkg::*;

	localparam int CB = CHANNEL_BITS;
	localparam logic [CB-1:0] FULL = {CB{1'b1}};

	// ---------------- stage 1: max, min, sector, channel difference
	logic                valid_s1;
	logic                ready_s1;
	logic [CB-1:0]       hi_s1;
	logic [CB-1:0]       lo_s1;
	sector_t             sector_s1;
	logic signed [CB:0]  diff_s1;

	logic [CB-1:0]       hi_c;
	logic [CB-1:0]       lo_c;
	sector_t             sector_c;
	logic signed [CB:0]  diff_c;

	// ---------------- stage 2: spread, sum, gray test
	logic                valid_s2;
	logic                ready_s2;
	logic [CB-1:0]       d_s2;
	logic [CB:0]         sum_s2;
	logic                achrom_s2;
	sector_t             sector_s2;
	logic signed [CB:0]  diff_s2;

	// ---------------- stage 3: divisors and numerators
	logic                valid_s3;
	logic                ready_s3;
	logic [CB-1:0]       sat_rem_s3;
	logic [QUO_BITS-1:0] sat_num_s3;
	logic [CB-1:0]       sat_div_s3;
	logic [CB+2:0]       hue_rem_s3;
	logic [CB+2:0]       hue_div_s3;
	logic [CB:0]         lsum_s3;
	logic                achrom_s3;

	logic [CB:0]           q_full_c;
	logic [CB+2:0]         six_d_c;
	logic [CB+2:0]         base_c;
	logic signed [CB+3:0]  n_c;
	logic [CB+QUO_BITS-1:0] sat_n_c;

	// ---------------- divider chain, index 0 is fed by stage 3
	logic [QUO_BITS:0]   st_valid;
	logic [QUO_BITS:0]   st_ready;
	logic [CB-1:0]       st_sat_rem [0:QUO_BITS];
	logic [QUO_BITS-1:0] st_sat_num [0:QUO_BITS];
	logic [CB-1:0]       st_sat_div [0:QUO_BITS];
	logic [QUO_BITS-1:0] st_sat_quo [0:QUO_BITS];
	logic [CB+2:0]       st_hue_rem [0:QUO_BITS];
	logic [CB+2:0]       st_hue_div [0:QUO_BITS];
	logic [QUO_BITS-1:0] st_hue_quo [0:QUO_BITS];
	logic [CB:0]         st_lsum    [0:QUO_BITS];
	logic                st_achrom  [0:QUO_BITS];

	// backpressure: a stage takes a word when empty or when it empties too
	assign ready_s3     = !valid_s3 || st_ready[0];
	assign ready_s2     = !valid_s2 || ready_s3;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign pix_in.ready = ready_s1;

	// max and min with red winning ties, then green
	always_comb begin
		hi_c = pix_in.red;
		lo_c = pix_in.red;
		if (pix_in.green > hi_c) hi_c = pix_in.green;
		if (pix_in.blue > hi_c)  hi_c = pix_in.blue;
		if (pix_in.green < lo_c) lo_c = pix_in.green;
		if (pix_in.blue < lo_c)  lo_c = pix_in.blue;
		if (pix_in.red == hi_c) begin
			sector_c = SEC_RED;
			diff_c   = $signed({1'b0, pix_in.green}) - $signed({1'b0, pix_in.blue});
		end else if (pix_in.green == hi_c) begin
			sector_c = SEC_GREEN;
			diff_c   = $signed({1'b0, pix_in.blue}) - $signed({1'b0, pix_in.red});
		end else begin
			sector_c = SEC_BLUE;
			diff_c   = $signed({1'b0, pix_in.red}) - $signed({1'b0, pix_in.green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= pix_in.valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.valid && ready_s1) begin
			hi_s1     <= hi_c;
			lo_s1     <= lo_c;
			sector_s1 <= sector_c;
			diff_s1   <= diff_c;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			d_s2      <= hi_s1 - lo_s1;
			sum_s2    <= {1'b0, hi_s1} + {1'b0, lo_s1};
			achrom_s2 <= hi_s1 == lo_s1;
			sector_s2 <= sector_s1;
			diff_s2   <= diff_s1;
		end
	end

	// saturation divisor folds around half scale; hue numerator is
	// 2*k*d + e, wrapped into [0, 6d) for a red maximum with e < 0
	always_comb begin
		q_full_c = (sum_s2 > {1'b0, FULL}) ? ({FULL, 1'b0} - sum_s2) : sum_s2;
		six_d_c  = {1'b0, d_s2, 2'b00} + {2'b00, d_s2, 1'b0};
		case (sector_s2)
			SEC_GREEN: base_c = {2'b00, d_s2, 1'b0};
			SEC_BLUE:  base_c = {1'b0, d_s2, 2'b00};
			default:   base_c = '0;
		endcase
		n_c = $signed({1'b0, base_c}) + {{3{diff_s2[CB]}}, diff_s2};
		if (sector_s2 == SEC_RED && diff_s2 < 0) begin
			n_c = n_c + $signed({1'b0, six_d_c});
		end
		// d * 65535 as d * 2^16 - d
		sat_n_c = {d_s2, {QUO_BITS{1'b0}}} - {{QUO_BITS{1'b0}}, d_s2};
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			sat_rem_s3 <= sat_n_c[CB+QUO_BITS-1:QUO_BITS];
			sat_num_s3 <= sat_n_c[QUO_BITS-1:0];
			sat_div_s3 <= q_full_c[CB-1:0];
			hue_rem_s3 <= n_c[CB+2:0];
			hue_div_s3 <= six_d_c;
			lsum_s3    <= sum_s2;
			achrom_s3  <= achrom_s2;
		end
	end

	assign st_valid[0]   = valid_s3;
	assign st_sat_rem[0] = sat_rem_s3;
	assign st_sat_num[0] = sat_num_s3;
	assign st_sat_div[0] = sat_div_s3;
	assign st_sat_quo[0] = '0;
	assign st_hue_rem[0] = hue_rem_s3;
	assign st_hue_div[0] = hue_div_s3;
	assign st_hue_quo[0] = '0;
	assign st_lsum[0]    = lsum_s3;
	assign st_achrom[0]  = achrom_s3;

	// sixteen divider stages, one quotient bit of each result per stage
	for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
		rhsl_div_step #(
			.CHANNEL_BITS(CB)
		) u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (st_valid[i]),
			.up_ready   (st_ready[i]),
			.up_sat_rem (st_sat_rem[i]),
			.up_sat_num (st_sat_num[i]),
			.up_sat_div (st_sat_div[i]),
			.up_sat_quo (st_sat_quo[i]),
			.up_hue_rem (st_hue_rem[i]),
			.up_hue_div (st_hue_div[i]),
			.up_hue_quo (st_hue_quo[i]),
			.up_lsum    (st_lsum[i]),
			.up_achrom  (st_achrom[i]),
			.dn_valid   (st_valid[i+1]),
			.dn_ready   (st_ready[i+1]),
			.dn_sat_rem (st_sat_rem[i+1]),
			.dn_sat_num (st_sat_num[i+1]),
			.dn_sat_div (st_sat_div[i+1]),
			.dn_sat_quo (st_sat_quo[i+1]),
			.dn_hue_rem (st_hue_rem[i+1]),
			.dn_hue_div (st_hue_div[i+1]),
			.dn_hue_quo (st_hue_quo[i+1]),
			.dn_lsum    (st_lsum[i+1]),
			.dn_achrom  (st_achrom[i+1])
		);
	end

	// last divider stage is the output register; gray pixels divide by
	// zero, so their quotients are masked here
	assign st_ready[QUO_BITS]    = pix_out.ready;
	assign pix_out.valid         = st_valid[QUO_BITS];
	assign pix_out.hue           = st_achrom[QUO_BITS] ? '0 : st_hue_quo[QUO_BITS];
	assign pix_out.saturation    = st_achrom[QUO_BITS] ? '0 : st_sat_quo[QUO_BITS];
	assign pix_out.lightness_sum = st_lsum[QUO_BITS];
	assign pix_out.achromatic    = st_achrom[QUO_BITS];

endmodule

`default_nettype wire

// ===== rtl/rhsl_checker.sv =====
// ----------------------------------------------------------------------------
// rhsl_checker
// port-level checks of the rgb to hsl converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rhsl_checker #(
	parameter int CHANNEL_BITS = rhsl_pkg::CHANNEL_BITS_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [rhsl_pkg::QUO_BITS-1:0] hue,
	input wire logic [rhsl_pkg::QUO_BITS-1:0] saturation,
	input wire logic [CHANNEL_BITS:0]         lightness_sum,
	input wire logic                          achromatic
);
	import rhsl_pkg::*;

	// a stalled word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hue) && $stable(saturation)
			&& $stable(lightness_sum) && $stable(achromatic))
		else $error("output word changed while stalled");

	// gray pixels carry no hue or saturation
	a_gray_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && achromatic |-> hue == '0 && saturation == '0)
		else $error("gray pixel with nonzero hue or saturation");

	// max equal to min makes the sum twice one channel
	a_gray_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && achromatic |-> !lightness_sum[0])
		else $error("gray pixel with odd lightness sum");

endmodule

bind rgb_to_hsl_converter rhsl_checker #(
	.CHANNEL_BITS(CHANNEL_BITS)
) u_rhsl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (pix_out.valid),
	.out_ready     (pix_out.ready),
	.hue           (pix_out.hue),
	.saturation    (pix_out.saturation),
	.lightness_sum (pix_out.lightness_sum),
	.achromatic    (pix_out.achromatic)
);

`default_nettype wire

// ===== bench/hsl_checker.sv =====
// ----------------------------------------------------------------------------
// hsl_checker
// watches both pixel channels, predicts each hsl word and compares in order
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_checker #(
	parameter int CB = rhsl_pkg::CHANNEL_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rhsl_in_if       pix_in,
	rhsl_out_if      pix_out,
	output int       fail_count,
	output int       pending,
	output int       words_checked,
	output int       gray_words
);

	import rhsl_pkg::*;

	localparam int MAX_REPORTS = 50;

	typedef struct packed {
		logic [QUO_BITS-1:0] hue;
		logic [QUO_BITS-1:0] saturation;
		logic [CB:0]         lightness_sum;
		logic                achromatic;
	} hsl_word_t;

	hsl_word_t hsl_queue [$];
	int        fails;
	int        outstanding;
	int        checked;
	int        grays;

	assign fail_count    = fails;
	assign pending       = outstanding;
	assign words_checked = checked;
	assign gray_words    = grays;

	// exact rational hue and saturation, truncated to the quotient width
	function automatic hsl_word_t hsl_of(input logic [CB-1:0] r, input logic [CB-1:0] g,
		input logic [CB-1:0] b);
		hsl_word_t       w;
		longint unsigned full, hi, lo, d, sum, q, sat, frac;
		longint          rs, gs, bs, delta, sixd;
		full = (64'd1 << CB) - 1;
		rs = r;
		gs = g;
		bs = b;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		sum = hi + lo;
		w.lightness_sum = sum[CB:0];
		if (hi == lo) begin
			w.hue        = '0;
			w.saturation = '0;
			w.achromatic = 1'b1;
			return w;
		end
		d   = hi - lo;
		q   = (sum > full) ? (2 * full - sum) : sum;
		sat = (d * 65535) / q;
		if (sat > 65535) sat = 65535;
		// max channel picks the sector, red before green before blue on ties
		if (r == hi) begin
			delta = gs - bs;
		end else if (g == hi) begin
			delta = 2 * longint'(d) + bs - rs;
		end else begin
			delta = 4 * longint'(d) + rs - gs;
		end
		sixd = 6 * longint'(d);
		if (delta < 0) delta += sixd;
		if (delta >= sixd) delta -= sixd;
		frac = (longint'(delta) * 65536) / sixd;
		w.hue        = frac[QUO_BITS-1:0];
		w.saturation = sat[QUO_BITS-1:0];
		w.achromatic = 1'b0;
		return w;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			if (fails < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		hsl_word_t want;
		if (!arst_n) begin
			hsl_queue.delete();
			outstanding = 0;
		end else begin
			if (pix_in.valid && pix_in.ready)
				hsl_queue.insert(hsl_queue.size(),
					hsl_of(pix_in.red, pix_in.green, pix_in.blue));
			if (pix_out.valid && pix_out.ready) begin
				if (hsl_queue.size() == 0) begin
					if (fails < MAX_REPORTS)
						$display("%0t: hsl word with none expected, hue %0d sat %0d sum %0d",
							$time, pix_out.hue, pix_out.saturation, pix_out.lightness_sum);
					fails++;
				end else begin
					want = hsl_queue.pop_front();
					compare_field("hue", 32'(want.hue), 32'(pix_out.hue));
					compare_field("saturation", 32'(want.saturation),
						32'(pix_out.saturation));
					compare_field("lightness_sum", 32'(want.lightness_sum),
						32'(pix_out.lightness_sum));
					compare_field("achromatic", 32'(want.achromatic),
						32'(pix_out.achromatic));
					checked++;
					if (want.achromatic) grays++;
				end
			end
			outstanding = hsl_queue.size();
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// pixel stream into the rgb to hsl converter under bursty input and stalls
// ----------------------------------------------------------------------------
//
// a directed set of pixels covers the corners: gray pixels, pure primaries,
// ties for the maximum, hue wrap below zero, saturation at full scale and the
// lightness sum on both sides of full scale. after that, random pixels biased
// toward ties, near-gray and extreme channels. the checker beside the block
// predicts every hsl word and compares it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int CB           = rhsl_pkg::CHANNEL_BITS_DEF;
	localparam int RANDOM_ITEMS = 1100;
	// the receiver holds off once, long enough to back up the whole pipeline
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 100;
	// drain on after the last expected hsl word has been checked
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT_CYCLES = 400000;

	localparam logic [CB-1:0] FULL = '1;

	logic clk = 1'b0;
	logic arst_n;

	int fail_count;
	int pending;
	int words_checked;
	int gray_words;
	int words_sent;
	int burst_left;
	int stall_cycles;
	bit hold_on;
	bit hold_done;

	rhsl_in_if  #(.CHANNEL_BITS(CB)) pix_in_bus ();
	rhsl_out_if #(.CHANNEL_BITS(CB)) pix_out_bus ();

	rgb_to_hsl_converter #(
		.CHANNEL_BITS(CB)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus)
	);

	hsl_checker #(
		.CB(CB)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_in        (pix_in_bus),
		.pix_out       (pix_out_bus),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked),
		.gray_words    (gray_words)
	);

	always #10 clk = ~clk;

	// hard stop in case the pipeline hangs
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	// cycles in which a pixel waited on the converter
	always @(posedge clk) begin
		if (arst_n && pix_in_bus.valid && !pix_in_bus.ready)
			stall_cycles++;
	end

	// random pixel, biased toward the interesting corners of the color cube
	function automatic logic [3*CB-1:0] pick_pixel();
		logic [CB-1:0] a, b, c;
		a = CB'($urandom);
		b = CB'($urandom);
		c = CB'($urandom);
		case ($urandom_range(0, 9))
			4: begin
				// gray
				b = a;
				c = a;
			end
			5: begin
				// two channels share the maximum
				b = a;
				c = CB'($urandom_range(0, a));
			end
			6: begin
				// two channels share the minimum
				b = a;
				c = CB'($urandom_range(a, FULL));
			end
			7: begin
				// almost gray, tiny spread
				b = a ^ CB'($urandom_range(0, 3));
				c = a ^ CB'($urandom_range(0, 3));
			end
			8: begin
				// channels at or next to the ends of the range
				a = ($urandom_range(0, 1) ? FULL : '0) ^ CB'($urandom_range(0, 1));
				b = ($urandom_range(0, 1) ? FULL : '0) ^ CB'($urandom_range(0, 1));
				c = ($urandom_range(0, 1) ? FULL : '0) ^ CB'($urandom_range(0, 1));
			end
			9: begin
				// full spread, third channel anywhere in between
				a = FULL;
				b = '0;
			end
			default: ;
		endcase
		// spread the pattern over all channel orders
		case ($urandom_range(0, 5))
			0:       return {a, b, c};
			1:       return {a, c, b};
			2:       return {b, a, c};
			3:       return {b, c, a};
			4:       return {c, a, b};
			default: return {c, b, a};
		endcase
	endfunction

	// offers one pixel word, with a random gap at the start of each burst
	task automatic put_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
		input logic [CB-1:0] b);
		int gap;
		if (burst_left == 0) begin
			// no gaps while the receiver holds off, keep the input pressed
			gap = (hold_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 48);
			if (gap != 0) begin
				pix_in_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pix_in_bus.valid <= 1'b1;
		pix_in_bus.red   <= r;
		pix_in_bus.green <= g;
		pix_in_bus.blue  <= b;
		@(posedge clk);
		while (!pix_in_bus.ready) @(posedge clk);
		words_sent++;
	endtask

	// receiver: stretches of steady ready, light and heavy stalls, one long hold
	initial begin
		int span, pct, k;
		pix_out_bus.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && words_sent >= HOLD_AT) begin
				hold_on = 1'b1;
				pix_out_bus.ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
				hold_on   = 1'b0;
				hold_done = 1'b1;
			end
			span = $urandom_range(4, 40);
			case ($urandom_range(0, 3))
				0:       pct = 100;
				1:       pct = 70;
				2:       pct = 40;
				default: pct = 10;
			endcase
			repeat (span) begin
				pix_out_bus.ready <= ($urandom_range(1, 100) <= pct);
				@(posedge clk);
			end
		end
	end

	// reset, stimulus and verdict
	initial begin
		logic [3*CB-1:0] px;
		arst_n           <= 1'b0;
		pix_in_bus.valid <= 1'b0;
		pix_in_bus.red   <= '0;
		pix_in_bus.green <= '0;
		pix_in_bus.blue  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gray pixels at both ends and the middle
		put_pixel('0, '0, '0);
		put_pixel(FULL, FULL, FULL);
		put_pixel(CB'(128), CB'(128), CB'(128));
		// pure primaries, one per sector
		put_pixel(FULL, '0, '0);
		put_pixel('0, FULL, '0);
		put_pixel('0, '0, FULL);
		// ties for the maximum: red beats green, green beats blue, red beats blue
		put_pixel(FULL, FULL, '0);
		put_pixel('0, FULL, FULL);
		put_pixel(FULL, '0, FULL);
		// red sector with blue above green, hue wraps just below a full turn
		put_pixel(FULL, '0, CB'(1));
		// one-step spread near black and near white, saturation hits full scale
		put_pixel(CB'(1), '0, '0);
		put_pixel('0, CB'(1), '0);
		put_pixel(FULL - CB'(1), FULL, FULL);
		// ordinary colors in each sector
		put_pixel(CB'(200), CB'(100), CB'(50));
		put_pixel(CB'(50), CB'(100), CB'(200));
		put_pixel(CB'(100), CB'(200), CB'(50));
		// lightness sum above, at and around full scale
		put_pixel(FULL, CB'(200), CB'(128));
		put_pixel(CB'(200), CB'(55), CB'(100));
		put_pixel(CB'(128), CB'(127), CB'(127));
		// hue exactly halfway through a sector
		put_pixel(CB'(170), CB'(85), '0);
		put_pixel('0, CB'(85), CB'(170));

		repeat (RANDOM_ITEMS) begin
			px = pick_pixel();
			put_pixel(px[3*CB-1:2*CB], px[2*CB-1:CB], px[CB-1:0]);
		end

		pix_in_bus.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d pixel words, checked %0d hsl words, %0d of them gray",
			words_sent, words_checked, gray_words);
		$display("input held back by the converter on %0d cycles", stall_cycles);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// ===== rgb_to_hsl_converter.f =====
rtl/rhsl_pkg.sv
rtl/rhsl_if.sv
rtl/rhsl_div_step.sv
rtl/rgb_to_hsl_converter.sv
rtl/rhsl_checker.sv
bench/hsl_checker.sv
bench/tb.sv
